[src/bm25f_pkg.sv]
// Package for the BM25F relevance scorer: widths, constants, item and request types.
// Used by every module of the block; depends on nothing.
package bm25f_pkg;

  localparam int unsigned FIELDS      = 5;
  localparam int unsigned DW          = 24;
  localparam int unsigned SLOT_W      = 3;
  localparam int unsigned SLOT_MAX    = 8;
  localparam int unsigned NUM_WEIGHTS = 5;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned DIV_W       = 42;
  localparam int unsigned DIV_CNT_W   = 6;
  localparam int unsigned LOG_IN_W    = 25;
  localparam int unsigned LOG_W       = 21;
  localparam int unsigned LOG_FRAC    = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_BASE = 3'd0;

  localparam logic [DW-1:0]      ONE_Q16       = 24'd65536;
  localparam logic [31:0]        LN2_Q32       = 32'd2977044472;
  localparam logic [DIV_W-1:0]   SAT_CONST_Q16 = 42'd111411;
  localparam logic [39:0]        MAX40         = '1;

  // Reciprocal of FIELDS for the IDF average: exact floor for any 32-bit magnitude
  localparam int unsigned  RECIP_SHIFT  = 35;
  localparam logic [35:0]  RECIP_FIELDS =
    36'(((64'd1 << RECIP_SHIFT) + 64'(FIELDS) - 64'd1) / 64'(FIELDS));

  // Divider step counts per operation (two quotient bits per cycle)
  localparam logic [DIV_CNT_W-1:0] STEPS_TF    = 6'd42;
  localparam logic [DIV_CNT_W-1:0] STEPS_RATIO = 6'd16;

  typedef logic [SLOT_MAX-1:0][DW-1:0] weights_t;

  typedef struct packed {
    logic [DW-1:0]     hits;
    logic [DW-1:0]     rows;   // already clamped to total
    logic [DW-1:0]     total;
    logic [DW-1:0]     words;
    logic [DW-1:0]     avg;
    logic [SLOT_W-1:0] slot;
    logic              close;
    logic              last;
  } item_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] steps;
    logic [DIV_W-1:0]     rem_init;
    logic [DIV_W-1:0]     dividend;
    logic [DIV_W-1:0]     den;
  } div_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_TF,
    S_WAIT,
    S_MUL,
    S_ACC,
    S_AVG,
    S_RATIO,
    S_RATIO_WAIT,
    S_SCORE,
    S_EMIT
  } back_state_e;

endpackage

[src/bm25f_fifo.sv]
// Two-entry request queue between the front and back parts of the scorer.
// Depends on bm25f_pkg.
module bm25f_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bm25f_pkg::item_t  item_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output bm25f_pkg::item_t  item_o
);
  import bm25f_pkg::*;

  item_t                      mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]          wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]            count_q;

  assign full_o  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i)      count_q <= count_q + 1'b1;
      else if (!push_i && pop_i) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= item_i;
  end

endmodule

[src/bm25f_front.sv]
// Front part: accept field items, clamp the hit-row count, tag slot and phrase close.
// Depends on bm25f_pkg.
module bm25f_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [5*bm25f_pkg::DW-1:0] in_data_i,
  input  logic                in_last_i,
  input  logic                full_i,
  output logic                push_o,
  output bm25f_pkg::item_t    item_o
);
  import bm25f_pkg::*;

  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [DW-1:0]     rows, total;
  logic              close;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  assign rows  = in_data_i[2*DW-1:DW];
  assign total = in_data_i[3*DW-1:2*DW];
  assign close = ({1'b0, slot_q} + (SLOT_W+1)'(1) >= (SLOT_W+1)'(FIELDS)) || in_last_i;

  always_comb begin
    item_o.hits  = in_data_i[DW-1:0];
    item_o.rows  = (rows > total) ? total : rows;
    item_o.total = total;
    item_o.words = in_data_i[4*DW-1:3*DW];
    item_o.avg   = in_data_i[5*DW-1:4*DW];
    item_o.slot  = slot_q;
    item_o.close = close;
    item_o.last  = in_last_i;
    slot_d       = close ? '0 : slot_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) slot_q <= '0;
    else if (push_o) slot_q <= slot_d;
  end

endmodule

[src/bm25f_log2.sv]
// Iterative log2 unit: unsigned Q5.16 result, one mantissa squaring per cycle.
// Depends on bm25f_pkg.
module bm25f_log2 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [bm25f_pkg::LOG_IN_W-1:0] x_i,
  output logic                          busy_o,
  output logic [bm25f_pkg::LOG_W-1:0]    result_o
);
  import bm25f_pkg::*;

  logic [4:0]          cnt_q;
  logic [4:0]          p_q, p;
  logic [31:0]         m_q, m_init;
  logic [LOG_FRAC-1:0] f_q;
  logic [63:0]         sq;
  logic [32:0]         t;

  always_comb begin
    p = '0;
    for (int i = 0; i < LOG_IN_W; i++) begin
      if (x_i[i]) p = 5'(i);
    end
    m_init = 32'(x_i) << (5'd31 - p);
    sq     = 64'(m_q) * 64'(m_q);
    t      = sq[63:31];
  end

  assign busy_o   = (cnt_q != '0);
  assign result_o = {p_q, f_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)     cnt_q <= '0;
    else if (start_i) cnt_q <= 5'(LOG_FRAC);
    else if (busy_o)  cnt_q <= cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      m_q <= m_init;
      p_q <= p;
      f_q <= '0;
    end else if (busy_o) begin
      m_q <= t[32] ? t[32:1] : t[31:0];
      f_q <= {f_q[LOG_FRAC-2:0], t[32]};
    end
  end

endmodule

[src/bm25f_div.sv]
// Shared restoring divider, two quotient bits per cycle.
// Depends on bm25f_pkg.
module bm25f_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bm25f_pkg::div_req_t         req_i,
  output logic                        busy_o,
  output logic [bm25f_pkg::DIV_W-1:0] quot_o
);
  import bm25f_pkg::*;

  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0]     rem_q, dvd_q, den_q, quot_q;
  logic [DIV_W:0]       r1, r2;
  logic [DIV_W-1:0]     rem1, rem2;
  logic                 ge1, ge2;

  always_comb begin
    r1   = {rem_q, dvd_q[DIV_W-1]};
    ge1  = (r1 >= {1'b0, den_q});
    rem1 = ge1 ? DIV_W'(r1 - {1'b0, den_q}) : r1[DIV_W-1:0];
    r2   = {rem1, dvd_q[DIV_W-2]};
    ge2  = (r2 >= {1'b0, den_q});
    rem2 = ge2 ? DIV_W'(r2 - {1'b0, den_q}) : r2[DIV_W-1:0];
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)          cnt_q <= '0;
    else if (req_i.start) cnt_q <= req_i.steps;
    else if (busy_o)      cnt_q <= cnt_q - DIV_CNT_W'(2);
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.rem_init;
      dvd_q  <= req_i.dividend;
      den_q  <= req_i.den;
      quot_q <= '0;
    end else if (busy_o) begin
      rem_q  <= rem2;
      dvd_q  <= {dvd_q[DIV_W-3:0], 2'b00};
      quot_q <= {quot_q[DIV_W-3:0], ge1, ge2};
    end
  end

endmodule

[src/bm25f_back.sv]
// Back part: per-field IDF and tf, phrase close, score accumulation and result register.
// Depends on bm25f_pkg, bm25f_log2 and bm25f_div.
module bm25f_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  bm25f_pkg::item_t    item_i,
  output logic                pop_o,
  input  bm25f_pkg::weights_t weights_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [31:0]         out_score_o,
  output logic                out_sat_o
);
  import bm25f_pkg::*;

  back_state_e state_q, state_d;
  item_t       cur_q;

  logic [47:0]        prod_q;
  logic [52:0]        idfp_q;
  logic               idf_neg_q;
  logic [48:0]        ph_q;
  logic [39:0]        pl_q;
  logic signed [31:0] idf_sum_q, score_q;
  logic [39:0]        wsum_q;
  logic               sat_q;
  logic [67:0]        avgp_q;
  logic [47:0]        cprod_q;
  logic               out_valid_q, out_sat_q;
  logic [31:0]        out_score_q;

  div_req_t               div_req;
  logic                   div_busy;
  logic [DIV_W-1:0]       quot;
  logic                   log_start, la_busy, lb_busy;
  logic [LOG_W-1:0]       la, lb;

  logic [DW-1:0]          a_avg, w;
  logic [50:0]            num;
  logic [26:0]            den_tf;
  logic signed [LOG_W:0]  d;
  logic [LOG_W-1:0]       d_mag;
  logic [40:0]            tf;
  logic [LOG_W-1:0]       r;
  logic signed [31:0]     idf_term;
  logic [49:0]            wt;
  logic [50:0]            wsum_s;
  logic [31:0]            mag, c;
  logic signed [33:0]     score_s;

  bm25f_log2 u_log_a (
    .clk_i, .rst_ni, .start_i(log_start),
    .x_i({cur_q.total - cur_q.rows, 1'b1}), .busy_o(la_busy), .result_o(la)
  );

  bm25f_log2 u_log_b (
    .clk_i, .rst_ni, .start_i(log_start),
    .x_i({cur_q.rows, 1'b1}), .busy_o(lb_busy), .result_o(lb)
  );

  bm25f_div u_div (
    .clk_i, .rst_ni, .req_i(div_req), .busy_o(div_busy), .quot_o(quot)
  );

  // Datapath arithmetic
  always_comb begin
    a_avg    = (cur_q.avg == '0) ? DW'(1) : cur_q.avg;
    w        = weights_i[cur_q.slot];
    num      = 51'({prod_q, 2'b00}) + 51'(prod_q);
    den_tf   = 27'({a_avg, 1'b0}) + 27'(a_avg) + 27'({cur_q.words, 1'b0});
    d        = $signed({1'b0, la}) - $signed({1'b0, lb});
    d_mag    = d[LOG_W] ? LOG_W'(-d) : d[LOG_W-1:0];
    tf       = (cur_q.words == '0) ? '0 : quot[40:0];
    r        = idfp_q[52:32];
    if (cur_q.total == '0)  idf_term = '0;
    else if (idf_neg_q)     idf_term = -$signed(32'(r));
    else                    idf_term = $signed(32'(r));
    wt       = 50'(ph_q) + 50'(pl_q[39:16]);
    wsum_s   = 51'(wsum_q) + 51'(wt);
    mag      = idf_sum_q[31] ? 32'(-idf_sum_q) : 32'(idf_sum_q);
    c        = cprod_q[47:16];
    score_s  = idf_sum_q[31] ? 34'(score_q) - $signed({2'b00, c})
                             : 34'(score_q) + $signed({2'b00, c});
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:       if (!empty_i) state_d = S_PREP;
      S_PREP:       state_d = S_TF;
      S_TF:         state_d = S_WAIT;
      S_WAIT:       if (!div_busy && !la_busy && !lb_busy) state_d = S_MUL;
      S_MUL:        state_d = S_ACC;
      S_ACC:        state_d = cur_q.close ? S_AVG : S_IDLE;
      S_AVG:        state_d = S_RATIO;
      S_RATIO:      state_d = S_RATIO_WAIT;
      S_RATIO_WAIT: if (!div_busy) state_d = S_SCORE;
      S_SCORE:      state_d = cur_q.last ? S_EMIT : S_IDLE;
      S_EMIT:       if (!out_valid_q) state_d = S_IDLE;
      default:      state_d = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    pop_o            = 1'b0;
    log_start        = 1'b0;
    div_req.start    = 1'b0;
    div_req.steps    = STEPS_TF;
    div_req.rem_init = DIV_W'(num[50:26]);
    div_req.dividend = {num[25:0], 16'b0};
    div_req.den      = DIV_W'(den_tf);
    unique case (state_q)
      S_IDLE: pop_o = !empty_i;
      S_PREP: log_start = 1'b1;
      S_TF:   div_req.start = (cur_q.words != '0);
      S_RATIO: begin
        div_req.start    = 1'b1;
        div_req.steps    = STEPS_RATIO;
        div_req.rem_init = DIV_W'(wsum_q);
        div_req.dividend = '0;
        div_req.den      = DIV_W'(wsum_q) + SAT_CONST_Q16;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idf_sum_q   <= '0;
      wsum_q      <= '0;
      score_q     <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_ACC: begin
          idf_sum_q <= idf_sum_q + idf_term;
          if (wsum_s > 51'(MAX40)) begin
            wsum_q <= MAX40;
            sat_q  <= 1'b1;
          end else begin
            wsum_q <= wsum_s[39:0];
          end
        end
        S_SCORE: begin
          if (score_s[33:31] != 3'b000 && score_s[33:31] != 3'b111) begin
            score_q <= score_s[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            sat_q   <= 1'b1;
          end else begin
            score_q <= score_s[31:0];
          end
          idf_sum_q <= '0;
          wsum_q    <= '0;
        end
        S_EMIT: begin
          if (!out_valid_q) begin
            out_valid_q <= 1'b1;
            score_q     <= '0;
            sat_q       <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= item_i;
    if (state_q == S_PREP) prod_q <= 48'(cur_q.hits) * 48'(a_avg);
    if (state_q == S_MUL) begin
      idfp_q    <= 53'(d_mag) * 53'(LN2_Q32);
      idf_neg_q <= d[LOG_W];
      ph_q      <= 49'(tf[40:16]) * 49'(w);
      pl_q      <= 40'(tf[15:0]) * 40'(w);
    end
    // IDF average magnitude by reciprocal multiplication
    if (state_q == S_AVG) avgp_q <= 68'(mag) * 68'(RECIP_FIELDS);
    if (state_q == S_RATIO_WAIT && !div_busy)
      cprod_q <= 48'(quot[15:0]) * 48'(avgp_q[RECIP_SHIFT+31:RECIP_SHIFT]);
    if (state_q == S_EMIT && !out_valid_q) begin
      out_score_q <= score_q;
      out_sat_q   <= sat_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_score_o = out_score_q;
  assign out_sat_o   = out_sat_q;

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_busy) else $error("divider restarted while busy");

  a_log_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    log_start |-> (!la_busy && !lb_busy)) else $error("log unit restarted while busy");

  a_close_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCORE) |=> (idf_sum_q == '0 && wsum_q == '0))
    else $error("phrase sums not cleared at close");

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && !out_valid_q) |=> (out_valid_q && score_q == '0 && !sat_q))
    else $error("query state not cleared on emission");

endmodule

[src/bm25f_relevance_score.sv]
// BM25F relevance scorer, top level: stream ports, weight registers, front/queue/back.
// Per field item the back runs both log units and the tf division (none when the field length
// is zero), then weights and adds; an item that closes a phrase adds the reciprocal average and
// ratio division, and the last item of a query registers the result. The back ends each item
// before it pops the next; the two-entry queue takes items while the back works or a result waits.
// Reset: asynchronous, active low; clears all sums, the slot count and weights to 1.0.
module bm25f_relevance_score (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Field items
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // tdata: hits_in_row, rows_with_hit, row_total, field_words, avg_words (24 bits each)
  input  logic [119:0]            s_axis_tdata,
  input  logic                    s_axis_tlast,   // last_of_query
  // Scores
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [31:0]             m_axis_tdata,   // score (signed Q16.16)
  output logic                    m_axis_tuser,   // saturated
  // Weight register writes
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [bm25f_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bm25f_pkg::DW-1:0]        cfg_data_i
);
  import bm25f_pkg::*;

  logic [DW-1:0] weight_q [NUM_WEIGHTS];
  weights_t      weights;
  item_t         front_item, head_item;
  logic          push, pop, full, empty;

  // Writes are taken at once; indexes beyond the weight list are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_WEIGHTS; i++) weight_q[i] <= ONE_Q16;
    end else if (cfg_valid_i) begin
      for (int i = 0; i < NUM_WEIGHTS; i++) begin
        if (cfg_index_i == CFG_WEIGHT_BASE + CFG_IDX_W'(i)) weight_q[i] <= cfg_data_i;
      end
    end
  end

  // Slots without a register weigh 1.0
  always_comb begin
    for (int i = 0; i < SLOT_MAX; i++) weights[i] = ONE_Q16;
    for (int i = 0; i < NUM_WEIGHTS; i++) weights[i] = weight_q[i];
  end

  // Front: accept, clamp and tag each request
  bm25f_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_data_i(s_axis_tdata), .in_last_i(s_axis_tlast),
    .full_i(full), .push_o(push), .item_o(front_item)
  );

  // Hold up to two requests between the two parts
  bm25f_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i(push), .item_i(front_item), .full_o(full),
    .pop_i(pop), .empty_o(empty), .item_o(head_item)
  );

  // Back: arithmetic, phrase close and result register
  bm25f_back u_back (
    .clk_i, .rst_ni,
    .empty_i(empty), .item_i(head_item), .pop_o(pop),
    .weights_i(weights),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_score_o(m_axis_tdata), .out_sat_o(m_axis_tuser)
  );

endmodule
